// ----- rtl/sorted_priority_queue_core_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define SPQ_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sorted priority queue assertion failed");
// Condition a implies condition b in the next cycle.
`define SPQ_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sorted priority queue assertion failed");
`else
`define SPQ_ASSERT_IMP(label, a, b)
`define SPQ_ASSERT_NXT(label, a, b)
`endif

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, request and status codes, and the control types shared by the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of cells and stored key width.
  localparam int DEPTH    = 8;
  localparam int KEY_BITS = 16;
  // Count register holds 0 to DEPTH.
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Request codes on req_type.
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_LIST = 2'd3
  } req_t;

  // Status codes on status.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_t;

  // Controller state.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_t;

  // Broadcast control word for the cell chain.
  typedef struct packed {
    cell_op_t            op;
    logic [KEY_BITS-1:0] key;
  } cell_ctl_t;

  // Position of one cell relative to the current fill level.
  typedef struct packed {
    logic occ;     // Cell holds a key.
    logic at_end;  // First free cell.
    logic tail;    // Cell holds the last key.
  } slot_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key and moves it to or from its neighbors on push, pop and list.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::cell_ctl_t           ctl,
  input  spq_pkg::slot_t               slot,
  input  logic [spq_pkg::KEY_BITS-1:0] left_key,
  input  logic                         left_gt,
  input  logic [spq_pkg::KEY_BITS-1:0] right_key,
  input  logic [spq_pkg::KEY_BITS-1:0] head_key,
  output logic [spq_pkg::KEY_BITS-1:0] key,
  output logic                         gt
);

  // This cell holds a key strictly greater than the incoming one, so it moves.
  assign gt = slot.occ && (key > ctl.key);

  // Key register: shift right on push, left on pop, rotate on list.
  always_ff @(posedge clk) begin
    case (ctl.op)
      spq_pkg::OP_PUSH: begin
        if (gt || slot.at_end) begin
          key <= left_gt ? left_key : ctl.key;
        end
      end
      spq_pkg::OP_POP: begin
        key <= right_key;
      end
      spq_pkg::OP_ROT: begin
        key <= slot.tail ? head_key : right_key;
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Decodes requests, keeps the fill count, sequences lists and holds the
// output word register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [15:0]                  key_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [15:0]                  key_out,
  output logic [3:0]                   count_out,
  output logic                         last,
  input  logic [spq_pkg::KEY_BITS-1:0] head_key,
  output spq_pkg::cell_ctl_t           ctl,
  output logic [spq_pkg::CNT_W-1:0]    count
);

  localparam logic [spq_pkg::CNT_W-1:0] CntFull = (spq_pkg::CNT_W)'(spq_pkg::DEPTH);
  localparam logic [spq_pkg::CNT_W-1:0] CntOne  = (spq_pkg::CNT_W)'(1);

  spq_pkg::state_t                  state, state_next;
  logic [spq_pkg::CNT_W-1:0]        count_next;
  logic [spq_pkg::CNT_W-1:0]        idx, idx_next;
  logic                             out_valid_next;
  logic                             load;
  spq_pkg::status_t                 ld_status;
  logic [spq_pkg::KEY_BITS-1:0]     ld_key;
  logic [spq_pkg::CNT_W-1:0]        ld_count;
  logic                             ld_last;
  logic                             out_free;
  logic                             take;
  logic                             empty;

  // The output register can take a new word this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != spq_pkg::ST_IDLE) || !out_free;
  assign take     = in_valid && !in_stall;
  assign empty    = (count == '0);

  // Request decode, list sequencing and output load.
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    ctl.op     = spq_pkg::OP_HOLD;
    ctl.key    = (spq_pkg::KEY_BITS)'(key_in);
    load       = 1'b0;
    ld_status  = spq_pkg::STAT_OK;
    ld_key     = '0;
    ld_count   = count;
    ld_last    = 1'b1;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (take) begin
          load = 1'b1;
          unique case (spq_pkg::req_t'(req_type))
            spq_pkg::REQ_PUSH: begin
              if (count == CntFull) begin
                ld_status = spq_pkg::STAT_FULL;
              end else begin
                ctl.op     = spq_pkg::OP_PUSH;
                count_next = count + CntOne;
                ld_count   = count + CntOne;
              end
            end
            spq_pkg::REQ_POP: begin
              if (empty) begin
                ld_status = spq_pkg::STAT_EMPTY;
              end else begin
                ctl.op     = spq_pkg::OP_POP;
                count_next = count - CntOne;
                ld_count   = count - CntOne;
                ld_key     = head_key;
              end
            end
            spq_pkg::REQ_PEEK: begin
              if (empty) begin
                ld_status = spq_pkg::STAT_EMPTY;
              end else begin
                ld_key = head_key;
              end
            end
            spq_pkg::REQ_LIST: begin
              if (empty) begin
                ld_status = spq_pkg::STAT_EMPTY;
              end else begin
                load       = 1'b0;
                idx_next   = '0;
                state_next = spq_pkg::ST_LIST;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      spq_pkg::ST_LIST: begin
        // Emit the head and rotate the occupied cells by one.
        if (out_free) begin
          load     = 1'b1;
          ctl.op   = spq_pkg::OP_ROT;
          ld_key   = head_key;
          ld_last  = (idx == count - CntOne);
          idx_next = idx + CntOne;
          if (ld_last) begin
            state_next = spq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (load) begin
      status    <= ld_status;
      key_out   <= 16'(ld_key);
      count_out <= 4'(ld_count);
      last      <= ld_last;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Keeps up to DEPTH keys in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, req_type, key_in) carries one
//   request word: push, pop head, peek head or list all. The output channel
//   (out_valid, out_stall, status, key_out, count_out, last) carries result
//   words; last marks the final word of each request.
//   For push, pop and peek, each cell compares and shifts in parallel, and
//   the result sits in the output register on the next cycle.
//   Such a request may be accepted every cycle, so throughput is one per
//   cycle while the receiver keeps up.
//   A non-empty list is accepted, then gives one word per held key while
//   the occupied cells rotate once around the chain.
//   No request is accepted during a list.
//   Reset empties the queue and clears the output valid flag; stored keys are
//   not cleared and are never shown before being written.
//   While the receiver stalls, the pending word holds and in_stall is high.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] key_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] key_out,
  output logic [3:0]  count_out,
  output logic        last
);

  localparam logic [spq_pkg::CNT_W-1:0] CntFull = (spq_pkg::CNT_W)'(spq_pkg::DEPTH);

  spq_pkg::cell_ctl_t           ctl;
  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::KEY_BITS-1:0] keys [spq_pkg::DEPTH];
  logic                         gts  [spq_pkg::DEPTH];
  logic                         push_full;
  logic                         pop_live;

  // Request decode, count and output register.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .key_in    (key_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .key_out   (key_out),
    .count_out (count_out),
    .last      (last),
    .head_key  (keys[0]),
    .ctl       (ctl),
    .count     (count)
  );

  // Chain of cells; cell 0 holds the head.
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    localparam logic [spq_pkg::CNT_W-1:0] Pos = (spq_pkg::CNT_W)'(i);
    spq_pkg::slot_t               slot;
    logic [spq_pkg::KEY_BITS-1:0] left_key;
    logic                         left_gt;
    logic [spq_pkg::KEY_BITS-1:0] right_key;

    assign slot.occ    = (Pos < count);
    assign slot.at_end = (Pos == count);
    assign slot.tail   = (Pos == count - (spq_pkg::CNT_W)'(1));

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (slot),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .right_key (right_key),
      .head_key  (keys[0]),
      .key       (keys[i]),
      .gt        (gts[i])
    );
  end

  // Accepted push on a full queue, and accepted pop on a non-empty one.
  assign push_full = in_valid && !in_stall && (req_type == spq_pkg::REQ_PUSH) &&
                     (count == CntFull);
  assign pop_live  = in_valid && !in_stall && (req_type == spq_pkg::REQ_POP) &&
                     (count != '0);

  // Checks on count bookkeeping and flow control.
  `SPQ_ASSERT_IMP(a_count_max, 1'b1, count <= CntFull)
  `SPQ_ASSERT_IMP(a_stall_on_held_word, out_valid && out_stall, in_stall)
  `SPQ_ASSERT_NXT(a_full_push_keeps_count, push_full, count == $past(count))
  `SPQ_ASSERT_NXT(a_pop_drops_count, pop_live, count == $past(count) - (spq_pkg::CNT_W)'(1))

endmodule

// ----- tb/tb_sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Sends directed and random push, pop, peek and list requests with random idle
// and stall bursts, predicts every result word from a behavioral copy of the
// queue, and checks each word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 225;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_SHOWN       = 10;

  // One request word as sent on the input channel.
  typedef struct {
    req_t        req;
    logic [15:0] key;
  } request_t;

  // One result word as seen on the output channel.
  typedef struct {
    status_t     st;
    logic [15:0] key;
    logic [3:0]  cnt;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type  = 2'd0;
  logic [15:0] key_in    = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] key_out;
  logic [3:0]  count_out;
  logic        last;

  // Requests waiting to be sent, and result words waiting to be seen.
  request_t pending_requests[$];
  result_t  expected_words[$];

  // Behavioral copy of the queue contents.
  logic [KEY_BITS-1:0] model_keys[DEPTH];
  int                  model_count = 0;

  // Word accepted at the previous edge, handed to the monitor.
  logic        acc_fire = 1'b0;
  logic [1:0]  acc_req  = 2'd0;
  logic [15:0] acc_key  = 16'd0;

  int   sent_count  = 0;
  int   send_gap    = 0;
  logic tail_phase  = 1'b0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  int   cycle_count = 0;

  int fail_count  = 0;
  int full_seen   = 0;
  int empty_seen  = 0;
  int words_seen  = 0;
  int longest_run = 0;

  sorted_priority_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .key_in    (key_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .key_out   (key_out),
    .count_out (count_out),
    .last      (last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_request(req_t req, logic [15:0] key);
    request_t item;
    item.req = req;
    item.key = key;
    pending_requests.push_back(item);
  endfunction

  function automatic void expect_word(status_t st, logic [15:0] key, int cnt, logic fin);
    result_t word;
    word.st   = st;
    word.key  = key;
    word.cnt  = cnt[3:0];
    word.last = fin;
    expected_words.push_back(word);
  endfunction

  // Apply one request to the queue copy and record the words it produces.
  function automatic void queue_response(req_t req, logic [15:0] key);
    int                  i;
    logic [KEY_BITS-1:0] head;
    if (req == REQ_PUSH) begin
      if (model_count >= DEPTH) begin
        full_seen++;
        expect_word(STAT_FULL, '0, model_count, 1'b1);
      end else begin
        // New key goes behind every equal key.
        i = model_count;
        while (i > 0 && model_keys[i-1] > key) begin
          model_keys[i] = model_keys[i-1];
          i--;
        end
        model_keys[i] = key;
        model_count++;
        expect_word(STAT_OK, '0, model_count, 1'b1);
      end
    end else if (model_count == 0) begin
      empty_seen++;
      expect_word(STAT_EMPTY, '0, 0, 1'b1);
    end else begin
      case (req)
        REQ_POP: begin
          head = model_keys[0];
          for (i = 1; i < model_count; i++) model_keys[i-1] = model_keys[i];
          model_count--;
          expect_word(STAT_OK, head, model_count, 1'b1);
        end
        REQ_PEEK: begin
          expect_word(STAT_OK, model_keys[0], model_count, 1'b1);
        end
        default: begin
          if (model_count > longest_run) longest_run = model_count;
          for (i = 0; i < model_count; i++)
            expect_word(STAT_OK, model_keys[i], model_count, (i + 1 == model_count));
        end
      endcase
    end
  endfunction

  // Driver: presents pending words, holds them while stalled, inserts idle bursts.
  always @(posedge clk) begin
    request_t item;
    if (rst) begin
      in_valid <= 1'b0;
      acc_fire <= 1'b0;
    end else begin
      acc_fire   <= in_valid && !in_stall;
      acc_req    <= req_type;
      acc_key    <= key_in;
      tail_phase <= (pending_requests.size() <= 40);
      if (in_valid && !in_stall) sent_count <= sent_count + 1;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_phase && hold_left == 0 && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          item = pending_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= item.req;
          key_in   <= item.key;
        end
      end
    end
  end

  // Monitor: predicts accepted words, checks results, drives the stall.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (acc_fire) queue_response(req_t'(acc_req), acc_key);

      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("Unexpected result word: status %0d key %h count %0d last %b",
                     status, key_out, count_out, last);
        end else begin
          want = expected_words.pop_front();
          if (status !== want.st || key_out !== want.key || count_out !== want.cnt ||
              last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
              $display("Result mismatch: expected status %0d key %h count %0d last %b",
                       want.st, want.key, want.cnt, want.last);
              $display("                 got status %0d key %h count %0d last %b",
                       status, key_out, count_out, last);
            end
          end
        end
      end

      // One long hold-off fills the block, then random stall bursts.
      if (!hold_done && sent_count >= 90) begin
        hold_done <= 1'b1;
        hold_left <= 120;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 13);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int   push_pct;
    int   pick;
    req_t req;
    logic [15:0] key;

    // Empty queue on every read kind.
    add_request(REQ_POP, 16'hFFFF);
    add_request(REQ_PEEK, 16'h0000);
    add_request(REQ_LIST, 16'hA5A5);
    // Fill to capacity with extremes and ties.
    add_request(REQ_PUSH, 16'hFFFF);
    add_request(REQ_PUSH, 16'h0000);
    add_request(REQ_PUSH, 16'h8000);
    add_request(REQ_PUSH, 16'h0000);
    add_request(REQ_PUSH, 16'h1234);
    add_request(REQ_PUSH, 16'hFFFF);
    add_request(REQ_PUSH, 16'h7FFF);
    add_request(REQ_PUSH, 16'h0001);
    // Refused push on a full queue, then a full listing.
    add_request(REQ_PUSH, 16'h5555);
    add_request(REQ_PEEK, 16'h5A5A);
    add_request(REQ_LIST, 16'h0000);
    add_request(REQ_POP, 16'h0000);
    add_request(REQ_POP, 16'hFFFF);
    add_request(REQ_POP, 16'h1111);
    add_request(REQ_PUSH, 16'hAAAA);
    add_request(REQ_LIST, 16'hFFFF);
    // Drain to empty.
    repeat (6) add_request(REQ_POP, 16'($urandom));

    // Random part in segments that lean toward filling or draining.
    push_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 16 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        req = REQ_PUSH;
      end else begin
        pick = $urandom_range(0, 9);
        req  = (pick < 6) ? REQ_POP : (pick < 8) ? REQ_PEEK : REQ_LIST;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)      key = 16'($urandom_range(0, 7));
      else if (pick == 4) key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else               key = 16'($urandom);
      add_request(req, key);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait until everything sent has been answered.
    do @(negedge clk);
    while (pending_requests.size() > 0 || in_valid || acc_fire || expected_words.size() > 0);
    repeat (20) @(negedge clk);

    $display("Sent %0d requests: %0d pushes refused when full, %0d reads on an empty queue.",
             sent_count, full_seen, empty_seen);
    $display("Checked %0d result words; longest listing held %0d keys.",
             words_seen, longest_run);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
